### rtl/core/mahs_pkg.sv
`timescale 1ns / 1ps

package mahs_pkg;

    localparam int HASH_BITS        = 10;
    localparam int SLOTS_PER_BUCKET = 4;

    localparam int BUCKET_COUNT = 1 << HASH_BITS;
    localparam int TOTAL_SLOTS  = BUCKET_COUNT * SLOTS_PER_BUCKET;
    localparam int SLOT_IDX_W   = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
    localparam int SLOT_ADDR_W  = $clog2(TOTAL_SLOTS);
    localparam int CNT_W        = $clog2(TOTAL_SLOTS + 1);

    localparam int MAC_W        = 48;
    localparam int WORD_W       = 32;
    localparam int STATUS_W     = 3;
    localparam int ELEM_COUNT_W = 13;

    // lookup3 start value plus the two-word length term (2 << 2)
    localparam logic [WORD_W-1:0] HASH_INIT = 32'hdeadbeef + 32'd8;
    localparam int MIX_STEPS = 7;
    localparam int MIX_CNT_W = $clog2(MIX_STEPS);

    typedef enum logic [1:0] {
        OP_ADD    = 2'd0,
        OP_DELETE = 2'd1,
        OP_TEST   = 2'd2,
        OP_FLUSH  = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_PRESENT   = 3'd3,
        ST_NO_ROOM   = 3'd4,
        ST_ZERO      = 3'd5
    } t_status;

    typedef struct packed {
        t_op              operation;
        logic [MAC_W-1:0] mac_address;
    } t_in_item;

    typedef struct packed {
        t_status                 status;
        logic [ELEM_COUNT_W-1:0] element_count;
    } t_out_item;

    typedef struct packed {
        logic                        vrow_rd;
        logic                        vrow_wr;
        logic [HASH_BITS-1:0]        row;
        logic [SLOTS_PER_BUCKET-1:0] vrow_wdata;
        logic                        addr_rd;
        logic                        addr_wr;
        logic [SLOT_IDX_W-1:0]       slot;
        logic [MAC_W-1:0]            addr_wdata;
    } t_store_ctrl;

endpackage

### rtl/core/mahs_hash.sv
`timescale 1ns / 1ps

module mahs_hash (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [31:0]                     i_seed,
    input  logic [31:0]                     i_word0,
    input  logic [31:0]                     i_word1,
    output logic                            o_done,
    output logic [mahs_pkg::HASH_BITS-1:0]  o_bucket
);
    import mahs_pkg::*;

    typedef enum logic [1:0] {
        SEL_A = 2'd0,
        SEL_B = 2'd1,
        SEL_C = 2'd2
    } t_reg_sel;

    logic                 r_busy;
    logic                 r_loaded;
    logic                 r_done;
    logic [MIX_CNT_W-1:0] r_step;
    logic [WORD_W-1:0]    r_init;
    logic [WORD_W-1:0]    r_a;
    logic [WORD_W-1:0]    r_b;
    logic [WORD_W-1:0]    r_c;

    logic [WORD_W-1:0]    mix_src;
    logic [WORD_W-1:0]    mix_dst;
    logic [WORD_W-1:0]    mix_rot;
    logic [WORD_W-1:0]    mix_out;
    t_reg_sel             dst_sel;

    // one xor-subtract step of the final mix per cycle; roles rotate c, a, b
    always_comb begin
        mix_src = r_b;
        mix_dst = r_c;
        mix_rot = {r_b[17:0], r_b[31:18]};
        dst_sel = SEL_C;
        case (r_step)
            3'd0: begin
                mix_src = r_b; mix_dst = r_c; dst_sel = SEL_C;
                mix_rot = {r_b[17:0], r_b[31:18]};
            end
            3'd1: begin
                mix_src = r_c; mix_dst = r_a; dst_sel = SEL_A;
                mix_rot = {r_c[20:0], r_c[31:21]};
            end
            3'd2: begin
                mix_src = r_a; mix_dst = r_b; dst_sel = SEL_B;
                mix_rot = {r_a[6:0], r_a[31:7]};
            end
            3'd3: begin
                mix_src = r_b; mix_dst = r_c; dst_sel = SEL_C;
                mix_rot = {r_b[15:0], r_b[31:16]};
            end
            3'd4: begin
                mix_src = r_c; mix_dst = r_a; dst_sel = SEL_A;
                mix_rot = {r_c[27:0], r_c[31:28]};
            end
            3'd5: begin
                mix_src = r_a; mix_dst = r_b; dst_sel = SEL_B;
                mix_rot = {r_a[17:0], r_a[31:18]};
            end
            3'd6: begin
                mix_src = r_b; mix_dst = r_c; dst_sel = SEL_C;
                mix_rot = {r_b[7:0], r_b[31:8]};
            end
            default: begin
                mix_src = r_b; mix_dst = r_c; dst_sel = SEL_C;
                mix_rot = {r_b[17:0], r_b[31:18]};
            end
        endcase
        mix_out = (mix_dst ^ mix_src) - mix_rot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_loaded <= 1'b0;
            r_done   <= 1'b0;
            r_step   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy   <= 1'b1;
                r_loaded <= 1'b0;
                r_step   <= '0;
            end else if (r_busy && !r_loaded) begin
                r_loaded <= 1'b1;
            end else if (r_busy) begin
                if (r_step == MIX_CNT_W'(MIX_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_step <= r_step + MIX_CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_init <= i_seed + HASH_INIT;
        end else if (r_busy && !r_loaded) begin
            r_a <= i_word0 + r_init;
            r_b <= i_word1 + r_init;
            r_c <= r_init;
        end else if (r_busy) begin
            case (dst_sel)
                SEL_A:   r_a <= mix_out;
                SEL_B:   r_b <= mix_out;
                default: r_c <= mix_out;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_bucket = r_c[HASH_BITS-1:0];

endmodule

### rtl/core/mahs_store.sv
`timescale 1ns / 1ps

module mahs_store (
    input  logic                                   i_clk,
    input  mahs_pkg::t_store_ctrl                  i_ctrl,
    output logic [mahs_pkg::SLOTS_PER_BUCKET-1:0]  o_vrow,
    output logic [mahs_pkg::MAC_W-1:0]             o_addr
);
    import mahs_pkg::*;

    // one row of valid marks per bucket, one address word per slot
    logic [SLOTS_PER_BUCKET-1:0] r_valid_mem [BUCKET_COUNT];
    logic [MAC_W-1:0]            r_addr_mem  [TOTAL_SLOTS];
    logic [SLOTS_PER_BUCKET-1:0] r_vrow_q;
    logic [MAC_W-1:0]            r_addr_q;
    logic [SLOT_ADDR_W-1:0]      slot_idx;

    assign slot_idx = SLOT_ADDR_W'(i_ctrl.row) * SLOT_ADDR_W'(SLOTS_PER_BUCKET)
                    + SLOT_ADDR_W'(i_ctrl.slot);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.vrow_wr) begin
            r_valid_mem[i_ctrl.row] <= i_ctrl.vrow_wdata;
        end
        if (i_ctrl.vrow_rd) begin
            r_vrow_q <= r_valid_mem[i_ctrl.row];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.addr_wr) begin
            r_addr_mem[slot_idx] <= i_ctrl.addr_wdata;
        end
        if (i_ctrl.addr_rd) begin
            r_addr_q <= r_addr_mem[slot_idx];
        end
    end

    assign o_vrow = r_vrow_q;
    assign o_addr = r_addr_q;

endmodule

### rtl/core/mac_address_hash_set.sv
// Hashed set of 48-bit MAC addresses, 1024 buckets of 4 slots.
// Input channel: i_in_valid / o_in_stall with i_in_data (operation, address).
// A word is taken when i_in_valid is high and o_in_stall is low; the block
// works on one word at a time and stalls the input until its result is loaded.
// Output channel: o_out_valid / i_out_stall with o_out_data (status, count).
// The result register holds while i_out_stall is high; the next input word is
// taken meanwhile, and its result waits in the sequencer until the register frees.
// Config channel: i_cfg_valid / o_cfg_ready (always ready) writes the hash seed.
// Sequence: add, delete and test load the seed into the seven-step mix unit,
// then scan the bucket one slot at a time (an occupied slot adds a read of the
// address memory) and stop at a match, then pass an update state before the
// result state. Zero address, and a full table on add, go straight to the
// result state. Flush sweeps the valid rows, one bucket a cycle, then loads
// its result. After reset the same sweep runs with the input stalled; the
// seed and the count reset to zero.
`timescale 1ns / 1ps

module mac_address_hash_set (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  mahs_pkg::t_in_item            i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output mahs_pkg::t_out_item           o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [31:0]                   i_cfg_data
);
    import mahs_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_HASH     = 7'b0000100,
        S_SCAN_RD  = 7'b0001000,
        S_SCAN_CMP = 7'b0010000,
        S_APPLY    = 7'b0100000,
        S_RESULT   = 7'b1000000
    } t_state;

    t_state                      r_state, n_state;
    logic [HASH_BITS-1:0]        r_row, n_row;
    logic                        r_flush, n_flush;
    logic [CNT_W-1:0]            r_count, n_count;
    logic [WORD_W-1:0]           r_seed;
    logic                        r_out_valid, n_out_valid;
    t_out_item                   r_out_item, n_out_item;
    t_op                         r_op, n_op;
    logic [MAC_W-1:0]            r_mac, n_mac;
    logic [HASH_BITS-1:0]        r_bucket, n_bucket;
    logic [SLOT_IDX_W-1:0]       r_slot, n_slot;
    logic                        r_hit, n_hit;
    logic [SLOT_IDX_W-1:0]       r_hit_slot, n_hit_slot;
    t_status                     r_status, n_status;

    t_store_ctrl                 ctrl;
    logic [SLOTS_PER_BUCKET-1:0] vrow_data;
    logic [MAC_W-1:0]            addr_data;
    logic                        hash_start;
    logic                        hash_done;
    logic [HASH_BITS-1:0]        hash_bucket;
    logic                        free_found;
    logic [SLOT_IDX_W-1:0]       free_slot;
    logic                        last_slot;
    logic [SLOTS_PER_BUCKET-1:0] free_mask;
    logic [SLOTS_PER_BUCKET-1:0] hit_mask;

    mahs_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_seed   (r_seed),
        .i_word0  (r_mac[31:0]),
        .i_word1  ({16'd0, r_mac[47:32]}),
        .o_done   (hash_done),
        .o_bucket (hash_bucket)
    );

    mahs_store u_store (
        .i_clk  (i_clk),
        .i_ctrl (ctrl),
        .o_vrow (vrow_data),
        .o_addr (addr_data)
    );

    // lowest free slot of the bucket row
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int i = SLOTS_PER_BUCKET - 1; i >= 0; i--) begin
            if (!vrow_data[i]) begin
                free_found = 1'b1;
                free_slot  = SLOT_IDX_W'(i);
            end
        end
    end

    assign last_slot = (r_slot == SLOT_IDX_W'(SLOTS_PER_BUCKET - 1));
    assign free_mask = SLOTS_PER_BUCKET'(1) << free_slot;
    assign hit_mask  = SLOTS_PER_BUCKET'(1) << r_hit_slot;

    always_comb begin
        n_state     = r_state;
        n_row       = r_row;
        n_flush     = r_flush;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_out_item  = r_out_item;
        n_op        = r_op;
        n_mac       = r_mac;
        n_bucket    = r_bucket;
        n_slot      = r_slot;
        n_hit       = r_hit;
        n_hit_slot  = r_hit_slot;
        n_status    = r_status;
        hash_start  = 1'b0;

        ctrl            = '0;
        ctrl.row        = r_bucket;
        ctrl.slot       = r_slot;
        ctrl.vrow_wdata = vrow_data;
        ctrl.addr_wdata = r_mac;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                ctrl.row        = r_row;
                ctrl.vrow_wr    = 1'b1;
                ctrl.vrow_wdata = '0;
                n_row           = r_row + HASH_BITS'(1);
                if (r_row == HASH_BITS'(BUCKET_COUNT - 1)) begin
                    n_flush = 1'b0;
                    if (r_flush) begin
                        n_count  = '0;
                        n_status = ST_DONE;
                        n_state  = S_RESULT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op  = i_in_data.operation;
                    n_mac = i_in_data.mac_address;
                    if (i_in_data.operation == OP_FLUSH) begin
                        n_flush = 1'b1;
                        n_row   = '0;
                        n_state = S_CLEAR;
                    end else if (i_in_data.operation == OP_ADD &&
                                 r_count >= CNT_W'(TOTAL_SLOTS)) begin
                        n_status = ST_NO_ROOM;
                        n_state  = S_RESULT;
                    end else if (i_in_data.mac_address == '0) begin
                        n_status = ST_ZERO;
                        n_state  = S_RESULT;
                    end else begin
                        hash_start = 1'b1;
                        n_state    = S_HASH;
                    end
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_bucket     = hash_bucket;
                    ctrl.row     = hash_bucket;
                    ctrl.vrow_rd = 1'b1;
                    n_slot       = '0;
                    n_hit        = 1'b0;
                    n_state      = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                // skip empty slots, fetch the address of occupied ones
                if (vrow_data[r_slot]) begin
                    ctrl.addr_rd = 1'b1;
                    n_state      = S_SCAN_CMP;
                end else if (last_slot) begin
                    n_state = S_APPLY;
                end else begin
                    n_slot = r_slot + SLOT_IDX_W'(1);
                end
            end
            S_SCAN_CMP: begin
                if (addr_data == r_mac) begin
                    n_hit      = 1'b1;
                    n_hit_slot = r_slot;
                    n_state    = S_APPLY;
                end else if (last_slot) begin
                    n_state = S_APPLY;
                end else begin
                    n_slot  = r_slot + SLOT_IDX_W'(1);
                    n_state = S_SCAN_RD;
                end
            end
            S_APPLY: begin
                n_state = S_RESULT;
                case (r_op)
                    OP_ADD: begin
                        if (r_hit) begin
                            n_status = ST_PRESENT;
                        end else if (free_found) begin
                            ctrl.vrow_wr    = 1'b1;
                            ctrl.vrow_wdata = vrow_data | free_mask;
                            ctrl.addr_wr    = 1'b1;
                            ctrl.slot       = free_slot;
                            n_count         = r_count + CNT_W'(1);
                            n_status        = ST_DONE;
                        end else begin
                            n_status = ST_NO_ROOM;
                        end
                    end
                    OP_DELETE: begin
                        if (r_hit) begin
                            ctrl.vrow_wr    = 1'b1;
                            ctrl.vrow_wdata = vrow_data & ~hit_mask;
                            if (r_count != '0) begin
                                n_count = r_count - CNT_W'(1);
                            end
                            n_status = ST_DONE;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                    OP_TEST: begin
                        n_status = r_hit ? ST_FOUND : ST_NOT_FOUND;
                    end
                    default: begin
                        n_status = ST_DONE;
                    end
                endcase
            end
            S_RESULT: begin
                // hold until the result register is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_item.status        = r_status;
                    n_out_item.element_count = ELEM_COUNT_W'(r_count);
                    n_state                  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_row       <= '0;
            r_flush     <= 1'b0;
            r_count     <= '0;
            r_seed      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row       <= n_row;
            r_flush     <= n_flush;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item <= n_out_item;
        r_op       <= n_op;
        r_mac      <= n_mac;
        r_bucket   <= n_bucket;
        r_slot     <= n_slot;
        r_hit      <= n_hit;
        r_hit_slot <= n_hit_slot;
        r_status   <= n_status;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;
    assign o_cfg_ready = 1'b1;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TOTAL_SLOTS))
        else $error("element count beyond table size");

    a_hash_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        hash_done |-> r_state == S_HASH)
        else $error("hash finished outside the hash phase");

    a_vrow_wr_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.vrow_wr |-> (r_state == S_CLEAR || r_state == S_APPLY))
        else $error("valid row written outside sweep or update");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state != S_IDLE)
        else $error("accepted word did not start the sequencer");

    a_result_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_RESULT))
        else $error("result loaded outside the result phase");

endmodule

### test/mac_address_hash_set_test.sv
`timescale 1ns / 1ps

module mac_address_hash_set_test;
    import mahs_pkg::*;

    localparam int          WATCHDOG_LIMIT = 20000;
    localparam int          HOLD_CYCLES    = 300;
    localparam int          RANDOM_WORDS   = 1400;
    localparam int          PHASES         = 5;
    localparam logic [31:0] JHASH_GOLDEN   = 32'hdeadbeef;

    typedef struct packed {
        t_op                     operation;
        logic [MAC_W-1:0]        mac;
        logic                    pinned;
        t_status                 status;
        logic [ELEM_COUNT_W-1:0] count;
    } t_script_row;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in_data   = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_data;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [31:0] i_cfg_data  = '0;

    // travels with each input word: take the typed result instead of the prediction
    logic        word_pinned = 1'b0;
    t_out_item   word_result = '0;

    // table image kept by the predictor
    logic [31:0]      model_seed;
    logic [MAC_W-1:0] model_mac [TOTAL_SLOTS];
    bit               model_used [TOTAL_SLOTS];
    int unsigned      model_held;
    t_out_item        pending_results [$];
    int               fail_count = 0;

    // sender-side bookkeeping
    logic [31:0]      gen_seed = '0;
    logic [MAC_W-1:0] bucket_mates [$];
    bit               offering = 1'b0;
    int               burst_left = 0;
    int               hold_requests = 0;

    int hold_served = 0;
    int hold_left   = 0;
    int mode_left   = 0;
    int stall_mode  = 0;
    int quiet_cycles = 0;

    t_script_row script [20] = '{
        '{OP_TEST,   48'h0000_0000_0001, 1'b1, ST_NOT_FOUND, 13'd0},
        '{OP_DELETE, 48'h0000_0000_0001, 1'b1, ST_NOT_FOUND, 13'd0},
        '{OP_ADD,    48'h0000_0000_0000, 1'b1, ST_ZERO,      13'd0},
        '{OP_DELETE, 48'h0000_0000_0000, 1'b1, ST_ZERO,      13'd0},
        '{OP_TEST,   48'h0000_0000_0000, 1'b1, ST_ZERO,      13'd0},
        '{OP_ADD,    48'hFFFF_FFFF_FFFF, 1'b1, ST_DONE,      13'd1},
        '{OP_ADD,    48'hFFFF_FFFF_FFFF, 1'b1, ST_PRESENT,   13'd1},
        '{OP_TEST,   48'hFFFF_FFFF_FFFF, 1'b1, ST_FOUND,     13'd1},
        '{OP_ADD,    48'h0000_0000_0001, 1'b1, ST_DONE,      13'd2},
        '{OP_ADD,    48'h8000_0000_0000, 1'b1, ST_DONE,      13'd3},
        '{OP_ADD,    48'h0000_FFFF_0000, 1'b1, ST_DONE,      13'd4},
        '{OP_DELETE, 48'hFFFF_FFFF_FFFF, 1'b1, ST_DONE,      13'd3},
        '{OP_TEST,   48'hFFFF_FFFF_FFFF, 1'b1, ST_NOT_FOUND, 13'd3},
        '{OP_ADD,    48'h5555_5555_5555, 1'b0, ST_DONE,      13'd0},
        '{OP_ADD,    48'hAAAA_AAAA_AAAA, 1'b0, ST_DONE,      13'd0},
        '{OP_DELETE, 48'h0000_0000_0001, 1'b0, ST_DONE,      13'd0},
        '{OP_FLUSH,  48'hAAAA_AAAA_AAAA, 1'b1, ST_DONE,      13'd0},
        '{OP_TEST,   48'h0000_0000_0001, 1'b1, ST_NOT_FOUND, 13'd0},
        '{OP_DELETE, 48'h8000_0000_0000, 1'b1, ST_NOT_FOUND, 13'd0},
        '{OP_FLUSH,  48'h0000_0000_0000, 1'b1, ST_DONE,      13'd0}
    };

    mac_address_hash_set dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    // two-word lookup3 final mix; address bytes 0..3 in the first word, 4..5 in the second
    function automatic logic [HASH_BITS-1:0] bucket_of_mac(input logic [MAC_W-1:0] mac,
                                                           input logic [31:0] seed);
        logic [31:0] start, a, b, c;
        start = seed + JHASH_GOLDEN + 32'd8;
        a = mac[31:0] + start;
        b = {16'h0000, mac[47:32]} + start;
        c = start;
        c = (c ^ b) - rotl(b, 14);
        a = (a ^ c) - rotl(c, 11);
        b = (b ^ a) - rotl(a, 25);
        c = (c ^ b) - rotl(b, 16);
        a = (a ^ c) - rotl(c, 4);
        b = (b ^ a) - rotl(a, 14);
        c = (c ^ b) - rotl(b, 24);
        return c[HASH_BITS-1:0];
    endfunction

    function automatic t_out_item apply_word(input t_in_item w);
        t_out_item r;
        int        base, hit, free, i;
        base = int'(bucket_of_mac(w.mac_address, model_seed)) * SLOTS_PER_BUCKET;
        hit  = -1;
        free = -1;
        for (i = base; i < base + SLOTS_PER_BUCKET; i++) begin
            if (model_used[i] && model_mac[i] == w.mac_address && hit < 0) hit = i;
            if (!model_used[i] && free < 0) free = i;
        end
        r.status = ST_DONE;
        if (w.operation == OP_FLUSH) begin
            for (i = 0; i < TOTAL_SLOTS; i++) model_used[i] = 1'b0;
            model_held = 0;
        end else if (w.operation == OP_ADD && model_held >= TOTAL_SLOTS) begin
            // full table wins over the zero-address check
            r.status = ST_NO_ROOM;
        end else if (w.mac_address == '0) begin
            r.status = ST_ZERO;
        end else begin
            case (w.operation)
                OP_ADD: begin
                    if (hit >= 0) begin
                        r.status = ST_PRESENT;
                    end else if (free < 0) begin
                        r.status = ST_NO_ROOM;
                    end else begin
                        model_used[free] = 1'b1;
                        model_mac[free]  = w.mac_address;
                        model_held++;
                    end
                end
                OP_DELETE: begin
                    if (hit >= 0) begin
                        model_used[hit] = 1'b0;
                        if (model_held > 0) model_held--;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                default: r.status = (hit >= 0) ? ST_FOUND : ST_NOT_FOUND;
            endcase
        end
        r.element_count = ELEM_COUNT_W'(model_held);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            model_seed = '0;
            model_held = 0;
            foreach (model_used[k]) model_used[k] = 1'b0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) model_seed = i_cfg_data;
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result word with none expected: status %0d, element_count %0d",
                           o_out_data.status, o_out_data.element_count);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_out_data.status);
                        fail_count++;
                    end
                    if (o_out_data.element_count !== want.element_count) begin
                        $error("element_count: expected %0d, got %0d",
                               want.element_count, o_out_data.element_count);
                        fail_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                want = apply_word(i_in_data);
                if (word_pinned) want = word_result;
                pending_results.push_back(want);
            end
        end
    end

    // output stall: long hold-off on request, otherwise a pattern that changes mode
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(50, 400);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 1) == 1);
                2:       i_out_stall <= ($urandom_range(0, 7) == 0);
                default: i_out_stall <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] random_mac();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[MAC_W-1:0];
    endfunction

    // collect n addresses that land in one bucket under the given seed, each differing from the first
    function automatic void gather_bucket_mates(input logic [31:0] seed, input int n);
        logic [MAC_W-1:0]     cand;
        logic [HASH_BITS-1:0] home;
        bucket_mates.delete();
        cand = random_mac();
        home = bucket_of_mac(cand, seed);
        bucket_mates.push_back(cand);
        while (bucket_mates.size() < n) begin
            cand = random_mac();
            if (bucket_of_mac(cand, seed) == home && cand != bucket_mates[0])
                bucket_mates.push_back(cand);
        end
    endfunction

    task automatic offer_word(input t_in_item w, input logic pinned, input t_out_item result);
        int gap;
        i_in_valid  <= 1'b1;
        i_in_data   <= w;
        word_pinned <= pinned;
        word_result <= result;
        offering = 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            burst_left = $urandom_range(0, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic offer_op(input t_op op, input logic [MAC_W-1:0] mac);
        t_in_item  w;
        t_out_item none;
        w.operation   = op;
        w.mac_address = mac;
        none = '0;
        offer_word(w, 1'b0, none);
    endtask

    task automatic offer_known(input t_op op, input logic [MAC_W-1:0] mac,
                               input t_status status, input int count);
        t_in_item  w;
        t_out_item r;
        w.operation     = op;
        w.mac_address   = mac;
        r.status        = status;
        r.element_count = ELEM_COUNT_W'(count);
        offer_word(w, 1'b1, r);
    endtask

    task automatic wait_drained();
        if (offering) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
        end
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= seed;
        gen_seed = seed;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
    endtask

    // place exactly one address per slot, tracking bucket occupancy on the sending side
    task automatic fill_table(output logic [MAC_W-1:0] last_mac);
        int               level [BUCKET_COUNT];
        int               placed, b;
        logic [MAC_W-1:0] cand;
        foreach (level[k]) level[k] = 0;
        placed = 0;
        while (placed < TOTAL_SLOTS) begin
            cand = random_mac();
            b = int'(bucket_of_mac(cand, gen_seed));
            if (cand != '0 && level[b] < SLOTS_PER_BUCKET) begin
                level[b]++;
                placed++;
                last_mac = cand;
                offer_op(OP_ADD, cand);
            end
        end
    endtask

    task automatic random_phase(input int words, input bit with_hold);
        logic [MAC_W-1:0] seen [$];
        t_op              op;
        logic [MAC_W-1:0] mac;
        int               n, pick;
        gather_bucket_mates(gen_seed, 7);
        for (n = 0; n < words; n++) begin
            if (with_hold && n == words / 3) hold_requests <= hold_requests + 1;
            pick = $urandom_range(0, 99);
            op = (pick < 42) ? OP_ADD : (pick < 62) ? OP_DELETE : (pick < 98) ? OP_TEST : OP_FLUSH;
            pick = $urandom_range(0, 99);
            if (pick < 3)
                mac = '0;
            else if (pick < 40 || seen.size() == 0)
                mac = random_mac();
            else if (pick < 70)
                mac = seen[$urandom_range(0, seen.size() - 1)];
            else
                mac = bucket_mates[$urandom_range(0, bucket_mates.size() - 1)];
            if (op == OP_ADD && mac != '0) begin
                seen.push_back(mac);
                if (seen.size() > 48) void'(seen.pop_front());
            end
            offer_op(op, mac);
        end
    endtask

    initial begin
        t_in_item         w;
        t_out_item        r;
        logic [MAC_W-1:0] last_mac;
        int               k;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < $size(script); k++) begin
            w.operation     = script[k].operation;
            w.mac_address   = script[k].mac;
            r.status        = script[k].status;
            r.element_count = script[k].count;
            offer_word(w, script[k].pinned, r);
        end

        // overflow one bucket, then free a slot and reuse it
        wait_drained();
        write_seed(32'hFFFF_FFFF);
        gather_bucket_mates(gen_seed, 5);
        for (k = 0; k < 5; k++) offer_op(OP_ADD, bucket_mates[k]);
        offer_op(OP_TEST, bucket_mates[4]);
        offer_op(OP_TEST, bucket_mates[2]);
        offer_op(OP_DELETE, bucket_mates[1]);
        offer_op(OP_ADD, bucket_mates[4]);
        offer_op(OP_ADD, bucket_mates[1]);
        offer_op(OP_DELETE, bucket_mates[1]);
        offer_known(OP_FLUSH, bucket_mates[0], ST_DONE, 0);

        // full table
        wait_drained();
        write_seed($urandom());
        fill_table(last_mac);
        offer_known(OP_ADD, random_mac() | 48'h1, ST_NO_ROOM, TOTAL_SLOTS);
        offer_known(OP_ADD, '0, ST_NO_ROOM, TOTAL_SLOTS);
        offer_known(OP_TEST, '0, ST_ZERO, TOTAL_SLOTS);
        offer_known(OP_DELETE, '0, ST_ZERO, TOTAL_SLOTS);
        offer_known(OP_TEST, last_mac, ST_FOUND, TOTAL_SLOTS);
        offer_known(OP_DELETE, last_mac, ST_DONE, TOTAL_SLOTS - 1);
        offer_known(OP_ADD, last_mac, ST_DONE, TOTAL_SLOTS);
        offer_known(OP_ADD, last_mac, ST_NO_ROOM, TOTAL_SLOTS);
        offer_known(OP_FLUSH, last_mac, ST_DONE, 0);

        for (k = 0; k < PHASES; k++) begin
            wait_drained();
            case (k)
                0:       write_seed(32'h0000_0000);
                1:       write_seed(32'h8000_0000);
                3:       write_seed(32'h0000_0001);
                default: write_seed($urandom());
            endcase
            random_phase(RANDOM_WORDS / PHASES, k == 1);
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
